@@ design/multichannel_variable_delay_top_defines.svh @@
// Assertion macros shared by the multichannel variable delay design.
`ifndef MULTICHANNEL_VARIABLE_DELAY_TOP_DEFINES_SVH
`define MULTICHANNEL_VARIABLE_DELAY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MVD_CHECK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mvd: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MVD_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mvd: next-cycle check failed");

`endif

@@ design/mvd_pkg.sv @@
// Shared constants and types of the multichannel variable delay line.
package mvd_pkg;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 32;
    localparam int DELAY_W  = 17;
    localparam int CFG_W    = 17;

    localparam int DEF_MAX_LENGTH = 65536;
    localparam int DEF_CHANNELS   = 8;
    localparam int RESET_LENGTH   = 44100;

    // Entries of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Where the output word of one item comes from.
    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_BYPASS,
        SRC_ZERO
    } t_src;

    localparam int SRC_W = $bits(t_src);

endpackage

@@ design/multichannel_variable_delay_top.sv @@
// Path: a word passes the front register, the queue, the store read with the memory stage, and the output register.
// Throughput: one word per cycle while the output is taken, set by the store's one write and one read port.
// Reset: length 44100 (capped at MAX_LENGTH), all write pointers and wrap flags zero.
// The store itself is not swept: per-channel wrap flags make unwritten entries read as
// zero, so there is no clearing pass after reset or after a length write.
// A length write clears pointers and flags; the configuration port is always ready.
`include "multichannel_variable_delay_top_defines.svh"

module multichannel_variable_delay_top #(
    parameter int MAX_LENGTH = mvd_pkg::DEF_MAX_LENGTH,
    parameter int CHANNELS   = mvd_pkg::DEF_CHANNELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mvd_pkg::CFG_W-1:0]          i_cfg_line_length,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mvd_pkg::CH_W-1:0]           i_channel,
    input  logic [mvd_pkg::SAMPLE_W-1:0]       i_sample_in,
    input  logic signed [mvd_pkg::DELAY_W-1:0] i_delay_amount,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mvd_pkg::SAMPLE_W-1:0]       o_sample_out
);

    import mvd_pkg::*;

    localparam int PW = $clog2(MAX_LENGTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = CW + PW;
    localparam int QW = SRC_W + 2 * AW + SAMPLE_W;

    // Front side of the queue.
    logic                fq_valid;
    logic                fq_ready;
    t_src                fq_src;
    logic [AW-1:0]       fq_waddr;
    logic [AW-1:0]       fq_raddr;
    logic [SAMPLE_W-1:0] fq_word;
    logic [QW-1:0]       fq_data;

    // Back side of the queue.
    logic                bq_valid;
    logic                bq_ready;
    logic [QW-1:0]       bq_data;
    t_src                bq_src;
    logic [AW-1:0]       bq_waddr;
    logic [AW-1:0]       bq_raddr;
    logic [SAMPLE_W-1:0] bq_word;

    // Front: take the word, clamp the delay, advance the channel pointer,
    // and classify the read as memory, bypass of the new word, or never written.
    mvd_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .CHANNELS   (CHANNELS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_line_length (i_cfg_line_length),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_channel         (i_channel),
        .i_sample_in       (i_sample_in),
        .i_delay_amount    (i_delay_amount),
        .o_q_valid         (fq_valid),
        .i_q_ready         (fq_ready),
        .o_q_src           (fq_src),
        .o_q_waddr         (fq_waddr),
        .o_q_raddr         (fq_raddr),
        .o_q_word          (fq_word)
    );

    assign fq_data = {fq_src, fq_waddr, fq_raddr, fq_word};

    // Queue: let the front keep accepting while the output side stalls.
    mvd_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_data  (fq_data),
        .o_pop_valid  (bq_valid),
        .i_pop_ready  (bq_ready),
        .o_pop_data   (bq_data)
    );

    assign bq_src   = t_src'(bq_data[QW-1 -: SRC_W]);
    assign bq_waddr = bq_data[2*AW+SAMPLE_W-1 -: AW];
    assign bq_raddr = bq_data[AW+SAMPLE_W-1 -: AW];
    assign bq_word  = bq_data[SAMPLE_W-1:0];

    // Back: write the new word and read the delayed one in the same cycle,
    // then hold the result in the output register until taken.
    mvd_back #(
        .MAX_LENGTH (MAX_LENGTH),
        .CHANNELS   (CHANNELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (bq_valid),
        .o_q_ready    (bq_ready),
        .i_q_src      (bq_src),
        .i_q_waddr    (bq_waddr),
        .i_q_raddr    (bq_raddr),
        .i_q_word     (bq_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    // A refused queue entry stays put, and the front then stops taking words.
    `MVD_CHECK_NEXT(a_front_hold, fq_valid && !fq_ready, fq_valid && $stable(fq_data))
    `MVD_CHECK_IMP(a_front_blocked, fq_valid && !fq_ready, !o_in_ready)

endmodule

@@ design/mvd_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module mvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mvd_front.sv @@
// Front end: accepts words, keeps length and write pointers, builds memory accesses.
module mvd_front #(
    parameter int MAX_LENGTH = mvd_pkg::DEF_MAX_LENGTH,
    parameter int CHANNELS   = mvd_pkg::DEF_CHANNELS,
    localparam int PW = $clog2(MAX_LENGTH),
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int AW = CW + PW
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mvd_pkg::CFG_W-1:0]          i_cfg_line_length,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mvd_pkg::CH_W-1:0]           i_channel,
    input  logic [mvd_pkg::SAMPLE_W-1:0]       i_sample_in,
    input  logic signed [mvd_pkg::DELAY_W-1:0] i_delay_amount,
    output logic                               o_q_valid,
    input  logic                               i_q_ready,
    output mvd_pkg::t_src                      o_q_src,
    output logic [AW-1:0]                      o_q_waddr,
    output logic [AW-1:0]                      o_q_raddr,
    output logic [mvd_pkg::SAMPLE_W-1:0]       o_q_word
);

    import mvd_pkg::*;

    localparam int LW        = $clog2(MAX_LENGTH + 1);
    localparam int XW        = (LW > CFG_W) ? LW : CFG_W;
    localparam int RESET_EFF = (RESET_LENGTH > MAX_LENGTH) ? MAX_LENGTH : RESET_LENGTH;

    logic [LW-1:0]       r_len;
    logic [PW-1:0]       r_pos [CHANNELS];
    logic [CHANNELS-1:0] r_wrapped;

    logic                r_a_valid;
    logic [CW-1:0]       r_a_ch;
    logic [SAMPLE_W-1:0] r_a_word;
    logic [PW-1:0]       r_a_pos;
    logic [PW-1:0]       r_a_dly;
    logic                r_a_wrapped;

    logic [CH_W-1:0] ch_tmp;
    logic [CW-1:0]   in_ch;
    logic [XW-1:0]   dly_ext;
    logic [PW-1:0]   in_dly;
    logic [PW-1:0]   cur_pos;
    logic [LW-1:0]   pos_inc;
    logic            wrap;
    logic [PW-1:0]   n_pos;
    logic [XW-1:0]   cfg_ext;
    logic [LW-1:0]   n_len;
    logic            accept;
    logic [PW:0]     diff;
    logic            borrow;
    logic [PW-1:0]   rd_pos;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_a_valid || i_q_ready;
    assign accept      = i_in_valid && o_in_ready;

    // Fold the channel number into range by repeated subtraction.
    always_comb begin
        ch_tmp = i_channel;
        for (int k = 0; k < (1 << CH_W); k++) begin
            if (int'(ch_tmp) >= CHANNELS) begin
                ch_tmp = ch_tmp - CH_W'(CHANNELS);
            end
        end
        in_ch = CW'(ch_tmp);
    end

    // Clamp the delay: negative to zero, too long to length minus one.
    always_comb begin
        dly_ext = XW'(i_delay_amount[DELAY_W-2:0]);
        if (i_delay_amount[DELAY_W-1]) begin
            in_dly = '0;
        end else if (dly_ext >= XW'(r_len)) begin
            in_dly = PW'(r_len - LW'(1));
        end else begin
            in_dly = PW'(i_delay_amount[DELAY_W-2:0]);
        end
    end

    assign cur_pos = r_pos[in_ch];
    assign pos_inc = LW'(cur_pos) + LW'(1);
    assign wrap    = (pos_inc == r_len);
    assign n_pos   = wrap ? '0 : PW'(pos_inc);

    always_comb begin
        cfg_ext = XW'(i_cfg_line_length);
        if (cfg_ext == '0) begin
            n_len = LW'(1);
        end else if (cfg_ext > XW'(MAX_LENGTH)) begin
            n_len = LW'(MAX_LENGTH);
        end else begin
            n_len = LW'(i_cfg_line_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LW'(RESET_EFF);
            r_wrapped <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_pos[k] <= '0;
            end
            r_a_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len     <= n_len;
                r_wrapped <= '0;
                for (int k = 0; k < CHANNELS; k++) begin
                    r_pos[k] <= '0;
                end
            end else if (accept) begin
                r_pos[in_ch] <= n_pos;
                if (wrap) begin
                    r_wrapped[in_ch] <= 1'b1;
                end
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (i_q_ready) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_ch      <= in_ch;
            r_a_word    <= i_sample_in;
            r_a_pos     <= cur_pos;
            r_a_dly     <= in_dly;
            r_a_wrapped <= r_wrapped[in_ch];
        end
    end

    // Read position: pos - d, or pos + len - d on borrow.
    assign diff   = {1'b0, r_a_pos} - {1'b0, r_a_dly};
    assign borrow = diff[PW];
    assign rd_pos = diff[PW-1:0] + (borrow ? PW'(r_len) : PW'(0));

    // Entries behind the pointer exist once written; ahead of it only after a wrap.
    always_comb begin
        if (r_a_dly == '0) begin
            o_q_src = SRC_BYPASS;
        end else if (borrow && !r_a_wrapped) begin
            o_q_src = SRC_ZERO;
        end else begin
            o_q_src = SRC_MEM;
        end
    end

    assign o_q_valid = r_a_valid;
    assign o_q_waddr = {r_a_ch, r_a_pos};
    assign o_q_raddr = {r_a_ch, rd_pos};
    assign o_q_word  = r_a_word;

endmodule

@@ design/mvd_fifo.sv @@
// Small register FIFO between front and back; depth is a power of two.
module mvd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mvd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int IW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [IW:0]      r_wp;
    logic [IW:0]      r_rp;
    logic             full;
    logic             empty;
    logic             push;
    logic             pop;

    assign empty        = (r_wp == r_rp);
    assign full         = (r_wp[IW] != r_rp[IW]) && (r_wp[IW-1:0] == r_rp[IW-1:0]);
    assign o_push_ready = !full;
    assign o_pop_valid  = !empty;
    assign push         = i_push_valid && !full;
    assign pop          = i_pop_ready && !empty;
    assign o_pop_data   = r_data[r_rp[IW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + (IW+1)'(1);
            end
            if (pop) begin
                r_rp <= r_rp + (IW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_data[r_wp[IW-1:0]] <= i_push_data;
        end
    end

endmodule

@@ design/mvd_back.sv @@
// Back end: writes and reads the sample store, selects the word, holds the output.
module mvd_back #(
    parameter int MAX_LENGTH = mvd_pkg::DEF_MAX_LENGTH,
    parameter int CHANNELS   = mvd_pkg::DEF_CHANNELS,
    localparam int PW = $clog2(MAX_LENGTH),
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int AW = CW + PW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  mvd_pkg::t_src                i_q_src,
    input  logic [AW-1:0]                i_q_waddr,
    input  logic [AW-1:0]                i_q_raddr,
    input  logic [mvd_pkg::SAMPLE_W-1:0] i_q_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mvd_pkg::SAMPLE_W-1:0] o_sample_out
);

    import mvd_pkg::*;

    logic                r_m_valid;
    t_src                r_m_src;
    logic [SAMPLE_W-1:0] r_m_word;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;

    logic                m_adv;
    logic                pop;
    logic [SAMPLE_W-1:0] rdata;
    logic [SAMPLE_W-1:0] n_sample;

    assign m_adv     = r_m_valid && (!r_out_valid || i_out_ready);
    assign o_q_ready = !r_m_valid || m_adv;
    assign pop       = i_q_valid && o_q_ready;

    // Read only on pop so the read data holds while the stage stalls.
    mvd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (1 << AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (pop),
        .i_waddr (i_q_waddr),
        .i_wdata (i_q_word),
        .i_re    (pop),
        .i_raddr (i_q_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        unique case (r_m_src)
            SRC_MEM:    n_sample = rdata;
            SRC_BYPASS: n_sample = r_m_word;
            SRC_ZERO:   n_sample = '0;
            default:    n_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_m_valid <= 1'b1;
            end else if (m_adv) begin
                r_m_valid <= 1'b0;
            end
            if (m_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_m_src  <= i_q_src;
            r_m_word <= i_q_word;
        end
        if (m_adv) begin
            r_out_sample <= n_sample;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;

endmodule
